// ===== sv/tptd_pkg.sv =====
// Package for the two-phase task dispatcher.
// Holds sizes, codes and the transaction, command and response structs.
// No dependencies.
package tptd_pkg;

    localparam int MAX_MAP    = 16;
    localparam int MAX_REDUCE = 16;
    localparam int BANK_DEPTH = (MAX_MAP > MAX_REDUCE) ? MAX_MAP : MAX_REDUCE;
    localparam int BANK_IDX_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    localparam int TASK_IDX_W = 4;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int GRANT_W    = 2;

    localparam logic [CNT_W-1:0] MAP_LIMIT    = CNT_W'(MAX_MAP);
    localparam logic [CNT_W-1:0] REDUCE_LIMIT = CNT_W'(MAX_REDUCE);

    localparam logic ACT_ASK    = 1'b0;
    localparam logic ACT_SUBMIT = 1'b1;

    localparam logic KIND_MAP    = 1'b0;
    localparam logic KIND_REDUCE = 1'b1;

    localparam logic [GRANT_W-1:0] GRANT_NONE   = 2'd0;
    localparam logic [GRANT_W-1:0] GRANT_MAP    = 2'd1;
    localparam logic [GRANT_W-1:0] GRANT_REDUCE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_COUNT = 2'd1;

    typedef struct packed {
        logic                  action;
        logic                  task_kind;
        logic [TASK_IDX_W-1:0] task_index;
    } in_t;

    typedef struct packed {
        logic [GRANT_W-1:0]    grant_kind;
        logic [TASK_IDX_W-1:0] grant_index;
        logic                  ok;
        logic                  job_done;
    } out_t;

    typedef struct packed {
        logic                  assign_en;
        logic                  submit_en;
        logic [BANK_IDX_W-1:0] idx;
    } bank_cmd_t;

    typedef struct packed {
        logic free;
        logic completed;
    } bank_rsp_t;

endpackage

// ===== sv/tptd_flag_bank.sv =====
// Assigned and completed flags for one phase of tasks.
// One addressed read, assign and submit updates.
// Depends on tptd_pkg.
module tptd_flag_bank (
    input  logic                aclk,
    input  logic                aresetn,
    input  tptd_pkg::bank_cmd_t cmd,
    output tptd_pkg::bank_rsp_t rsp
);

    logic [tptd_pkg::BANK_DEPTH-1:0] assigned_reg;
    logic [tptd_pkg::BANK_DEPTH-1:0] completed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            assigned_reg  <= '0;
            completed_reg <= '0;
        end else begin
            if (cmd.assign_en) begin
                assigned_reg[cmd.idx] <= 1'b1;
            end
            if (cmd.submit_en) begin
                assigned_reg[cmd.idx]  <= 1'b0;
                completed_reg[cmd.idx] <= 1'b1;
            end
        end
    end

    assign rsp.free      = !assigned_reg[cmd.idx] && !completed_reg[cmd.idx];
    assign rsp.completed = completed_reg[cmd.idx];

endmodule

// ===== sv/tptd_ctrl.sv =====
// Sequencer for the task dispatcher: config registers, completion counts,
// scan counter over the flag banks and the output register.
// Depends on tptd_pkg.
module tptd_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tptd_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tptd_pkg::out_t                      m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tptd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tptd_pkg::CNT_W-1:0]          cfg_data,
    output tptd_pkg::bank_cmd_t                 map_cmd,
    output tptd_pkg::bank_cmd_t                 red_cmd,
    input  tptd_pkg::bank_rsp_t                 map_rsp,
    input  tptd_pkg::bank_rsp_t                 red_rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUBMIT
    } state_t;

    state_t                       state_reg, state_next;
    tptd_pkg::in_t                item_reg, item_next;
    logic                         phase_reg, phase_next;
    logic [tptd_pkg::CNT_W-1:0]   scan_reg, scan_next;
    logic [tptd_pkg::CNT_W-1:0]   map_cfg_reg, map_cfg_next;
    logic [tptd_pkg::CNT_W-1:0]   red_cfg_reg, red_cfg_next;
    logic [tptd_pkg::CNT_W-1:0]   map_done_reg, map_done_next;
    logic [tptd_pkg::CNT_W-1:0]   red_done_reg, red_done_next;
    logic                         finished_reg, finished_next;
    logic                         m_valid_reg, m_valid_next;
    tptd_pkg::out_t               m_data_reg, m_data_next;

    logic [tptd_pkg::CNT_W-1:0]      mcnt, rcnt, scan_lim, sub_lim;
    logic [tptd_pkg::BANK_IDX_W-1:0] rd_idx;
    logic                            out_free, scan_free, sub_cmp, in_range;

    assign mcnt = (map_cfg_reg > tptd_pkg::MAP_LIMIT) ? tptd_pkg::MAP_LIMIT : map_cfg_reg;
    assign rcnt = (red_cfg_reg > tptd_pkg::REDUCE_LIMIT) ? tptd_pkg::REDUCE_LIMIT
                                                         : red_cfg_reg;

    assign scan_lim  = phase_reg ? rcnt : mcnt;
    assign sub_lim   = (item_reg.task_kind == tptd_pkg::KIND_REDUCE) ? rcnt : mcnt;
    assign in_range  = {1'b0, item_reg.task_index} < sub_lim;
    assign scan_free = phase_reg ? red_rsp.free : map_rsp.free;
    assign sub_cmp   = (item_reg.task_kind == tptd_pkg::KIND_REDUCE) ? red_rsp.completed
                                                                     : map_rsp.completed;
    assign out_free  = !m_valid_reg || m_ready;

    assign rd_idx = (state_reg == ST_SUBMIT)
                    ? tptd_pkg::BANK_IDX_W'(item_reg.task_index)
                    : scan_reg[tptd_pkg::BANK_IDX_W-1:0];

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        phase_next    = phase_reg;
        scan_next     = scan_reg;
        map_cfg_next  = map_cfg_reg;
        red_cfg_next  = red_cfg_reg;
        map_done_next = map_done_reg;
        red_done_next = red_done_reg;
        finished_next = finished_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        map_cmd       = '{assign_en: 1'b0, submit_en: 1'b0, idx: rd_idx};
        red_cmd       = '{assign_en: 1'b0, submit_en: 1'b0, idx: rd_idx};

        if (cfg_valid) begin
            case (cfg_index)
                tptd_pkg::CFG_MAP_COUNT:    map_cfg_next = cfg_data;
                tptd_pkg::CFG_REDUCE_COUNT: red_cfg_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    if (s_data.action == tptd_pkg::ACT_ASK) begin
                        phase_next = !(map_done_reg < mcnt);
                        scan_next  = '0;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_SUBMIT;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_reg >= scan_lim) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{grant_kind: tptd_pkg::GRANT_NONE, grant_index: '0,
                                         ok: 1'b1, job_done: finished_reg};
                        state_next   = ST_IDLE;
                    end
                end else if (scan_free) begin
                    if (out_free) begin
                        map_cmd.assign_en = !phase_reg;
                        red_cmd.assign_en = phase_reg;
                        m_valid_next = 1'b1;
                        m_data_next  = '{grant_kind: phase_reg ? tptd_pkg::GRANT_REDUCE
                                                               : tptd_pkg::GRANT_MAP,
                                         grant_index: tptd_pkg::TASK_IDX_W'(scan_reg),
                                         ok: 1'b1, job_done: finished_reg};
                        state_next   = ST_IDLE;
                    end
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_SUBMIT: begin
                if (out_free) begin
                    if (in_range) begin
                        if (item_reg.task_kind == tptd_pkg::KIND_REDUCE) begin
                            red_cmd.submit_en = 1'b1;
                            if (!sub_cmp) begin
                                red_done_next = red_done_reg + 1'b1;
                            end
                        end else begin
                            map_cmd.submit_en = 1'b1;
                            if (!sub_cmp) begin
                                map_done_next = map_done_reg + 1'b1;
                            end
                        end
                    end
                    finished_next = finished_reg ||
                                    ((map_done_next >= mcnt) && (red_done_next >= rcnt));
                    m_valid_next  = 1'b1;
                    m_data_next   = '{grant_kind: tptd_pkg::GRANT_NONE, grant_index: '0,
                                      ok: in_range, job_done: finished_next};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        phase_reg  <= phase_next;
        scan_reg   <= scan_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            map_cfg_reg  <= '0;
            red_cfg_reg  <= '0;
            map_done_reg <= '0;
            red_done_reg <= '0;
            finished_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            map_cfg_reg  <= map_cfg_next;
            red_cfg_reg  <= red_cfg_next;
            map_done_reg <= map_done_next;
            red_done_reg <= red_done_next;
            finished_reg <= finished_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

// ===== sv/two_phase_task_dispatcher.sv =====
// Top level of the two-phase task dispatcher.
// Depends on tptd_pkg, tptd_ctrl and tptd_flag_bank.
//
// Hands out map tasks, then reduce tasks once every map task has completed,
// and records submitted tasks. An ask walks the flag bank of the current
// phase one entry per cycle with a single shared compare, stopping at the
// first free entry or after N entries, N being the effective task count of
// that phase. The input is not ready while an item is in progress; a result
// may wait in the output register while the next item is taken, and the
// sequencer stalls at its last step until that register is free. The config
// port is always ready; counts above the maximum saturate to it.
module two_phase_task_dispatcher (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tptd_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tptd_pkg::out_t                  m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tptd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tptd_pkg::CNT_W-1:0]      cfg_data
);

    tptd_pkg::bank_cmd_t map_cmd, red_cmd;
    tptd_pkg::bank_rsp_t map_rsp, red_rsp;

    tptd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .map_cmd   (map_cmd),
        .red_cmd   (red_cmd),
        .map_rsp   (map_rsp),
        .red_rsp   (red_rsp)
    );

    tptd_flag_bank u_map_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (map_cmd),
        .rsp     (map_rsp)
    );

    tptd_flag_bank u_red_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (red_cmd),
        .rsp     (red_rsp)
    );

endmodule

// ===== sv/tptd_checker.sv =====
// Port-level checks for the two-phase task dispatcher, bound to the top.
// Depends on tptd_pkg.
module tptd_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input tptd_pkg::out_t m_data
);

    logic done_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_seen_reg <= 1'b0;
        end else if (m_valid && m_ready && m_data.job_done) begin
            done_seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction changed while stalled");

    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && done_seen_reg |-> m_data.job_done)
        else $error("job_done fell after being reported");

    a_no_grant_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.grant_kind == tptd_pkg::GRANT_NONE |-> m_data.grant_index == '0)
        else $error("non-zero index without a grant");

    a_reject_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.ok |-> m_data.grant_kind == tptd_pkg::GRANT_NONE)
        else $error("rejected transaction carries a grant");

endmodule

bind two_phase_task_dispatcher tptd_checker u_tptd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== verif/two_phase_task_dispatcher_tb.sv =====
// Self-checking testbench for two_phase_task_dispatcher.
// Drives a directed run and a randomised run across several count settings,
// predicting every response. Depends on tptd_pkg and the dispatcher RTL.
module two_phase_task_dispatcher_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 89;

    // Predicts grants and completions; holds the responses still owed by the block.
    class task_ledger;
        logic [tptd_pkg::BANK_DEPTH-1:0] busy[2];
        logic [tptd_pkg::BANK_DEPTH-1:0] done[2];
        int unsigned                     tally[2];
        logic [tptd_pkg::CNT_W-1:0]      count_reg[2];
        bit                              finished;
        tptd_pkg::out_t                  owed[$];
        int                              errors;

        function new();
            for (int k = 0; k < 2; k++) begin
                busy[k]      = '0;
                done[k]      = '0;
                tally[k]     = 0;
                count_reg[k] = '0;
            end
            finished = 1'b0;
            errors   = 0;
        endfunction

        function void write_reg(logic [tptd_pkg::CFG_IDX_W-1:0] idx,
                                logic [tptd_pkg::CNT_W-1:0] value);
            if (idx == tptd_pkg::CFG_MAP_COUNT) begin
                count_reg[tptd_pkg::KIND_MAP] = value;
            end else if (idx == tptd_pkg::CFG_REDUCE_COUNT) begin
                count_reg[tptd_pkg::KIND_REDUCE] = value;
            end
        endfunction

        function int unsigned task_limit(logic kind);
            int unsigned cap;
            cap = (kind == tptd_pkg::KIND_MAP) ? tptd_pkg::MAX_MAP : tptd_pkg::MAX_REDUCE;
            return (count_reg[kind] > cap) ? cap : 32'(count_reg[kind]);
        endfunction

        function void note_request(tptd_pkg::in_t req);
            tptd_pkg::out_t rsp;
            int unsigned    lim[2];
            logic           phase;
            logic           k;
            lim[tptd_pkg::KIND_MAP]    = task_limit(tptd_pkg::KIND_MAP);
            lim[tptd_pkg::KIND_REDUCE] = task_limit(tptd_pkg::KIND_REDUCE);
            rsp.grant_kind   = tptd_pkg::GRANT_NONE;
            rsp.grant_index  = '0;
            rsp.ok           = 1'b1;
            if (req.action == tptd_pkg::ACT_ASK) begin
                phase = (tally[tptd_pkg::KIND_MAP] < lim[tptd_pkg::KIND_MAP])
                        ? tptd_pkg::KIND_MAP : tptd_pkg::KIND_REDUCE;
                for (int i = 0; i < lim[phase]; i++) begin
                    if (!done[phase][i] && !busy[phase][i]) begin
                        busy[phase][i]  = 1'b1;
                        rsp.grant_kind  = (phase == tptd_pkg::KIND_MAP)
                                          ? tptd_pkg::GRANT_MAP : tptd_pkg::GRANT_REDUCE;
                        rsp.grant_index = tptd_pkg::TASK_IDX_W'(i);
                        break;
                    end
                end
            end else begin
                k = req.task_kind;
                if (req.task_index < lim[k]) begin
                    if (!done[k][req.task_index]) tally[k]++;
                    done[k][req.task_index] = 1'b1;
                    busy[k][req.task_index] = 1'b0;
                end else begin
                    rsp.ok = 1'b0;
                end
                if (tally[tptd_pkg::KIND_MAP] >= lim[tptd_pkg::KIND_MAP] &&
                    tally[tptd_pkg::KIND_REDUCE] >= lim[tptd_pkg::KIND_REDUCE])
                    finished = 1'b1;
            end
            rsp.job_done = finished;
            owed = {owed, rsp};
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_reply(tptd_pkg::out_t got);
            tptd_pkg::out_t want;
            if (owed.size() == 0) begin
                $error("unexpected response transaction: %p", got);
                errors++;
                return;
            end
            want = owed.pop_front();
            compare("grant_kind", 8'(want.grant_kind), 8'(got.grant_kind));
            compare("grant_index", 8'(want.grant_index), 8'(got.grant_index));
            compare("ok", 8'(want.ok), 8'(got.ok));
            compare("job_done", 8'(want.job_done), 8'(got.job_done));
        endfunction

        // Picks a task currently handed out, so that its submit is well formed.
        function bit pick_busy(output logic kind,
                               output logic [tptd_pkg::TASK_IDX_W-1:0] idx);
            int start;
            int p;
            start = $urandom_range(0, 2 * tptd_pkg::BANK_DEPTH - 1);
            kind  = tptd_pkg::KIND_MAP;
            idx   = '0;
            for (int n = 0; n < 2 * tptd_pkg::BANK_DEPTH; n++) begin
                p = (start + n) % (2 * tptd_pkg::BANK_DEPTH);
                if (busy[p / tptd_pkg::BANK_DEPTH][p % tptd_pkg::BANK_DEPTH]) begin
                    kind = (p / tptd_pkg::BANK_DEPTH == 0) ? tptd_pkg::KIND_MAP
                                                           : tptd_pkg::KIND_REDUCE;
                    idx  = tptd_pkg::TASK_IDX_W'(p % tptd_pkg::BANK_DEPTH);
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    tptd_pkg::in_t                  s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    tptd_pkg::out_t                 m_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tptd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tptd_pkg::CNT_W-1:0]     cfg_data  = '0;

    task_ledger ledger = new();
    int send_idle_pct = 11;
    int recv_idle_pct = 63;
    int stall_cycles  = 0;

    two_phase_task_dispatcher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) ledger.check_reply(m_data);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $error("no transaction for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic tptd_pkg::in_t mk(logic action, logic kind,
                                         logic [tptd_pkg::TASK_IDX_W-1:0] idx);
        tptd_pkg::in_t req;
        req.action     = action;
        req.task_kind  = kind;
        req.task_index = idx;
        return req;
    endfunction

    // Mostly asks and submits of handed-out tasks; the rest in-range or arbitrary submits.
    function automatic tptd_pkg::in_t next_request();
        tptd_pkg::in_t                   req;
        int                              roll;
        int unsigned                     lim;
        logic                            kind;
        logic [tptd_pkg::TASK_IDX_W-1:0] idx;
        roll           = $urandom_range(0, 99);
        req.action     = tptd_pkg::ACT_ASK;
        req.task_kind  = 1'($urandom_range(0, 1));
        req.task_index = tptd_pkg::TASK_IDX_W'($urandom_range(0, 15));
        if (roll >= 45 && roll < 80) begin
            if (ledger.pick_busy(kind, idx)) req = mk(tptd_pkg::ACT_SUBMIT, kind, idx);
        end else if (roll >= 80 && roll < 90) begin
            req.action = tptd_pkg::ACT_SUBMIT;
            lim = ledger.task_limit(req.task_kind);
            if (lim != 0) req.task_index = tptd_pkg::TASK_IDX_W'($urandom_range(0, lim - 1));
        end else if (roll >= 90) begin
            req.action = tptd_pkg::ACT_SUBMIT;
        end
        return req;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input tptd_pkg::in_t req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        ledger.note_request(req);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [tptd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tptd_pkg::CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        ledger.write_reg(idx, value);
        @(negedge aclk);
    endtask

    task automatic set_counts(input logic [tptd_pkg::CNT_W-1:0] map_n,
                              input logic [tptd_pkg::CNT_W-1:0] red_n);
        write_reg(tptd_pkg::CFG_MAP_COUNT, map_n);
        write_reg(tptd_pkg::CFG_REDUCE_COUNT, red_n);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (ledger.pending() != 0) @(negedge aclk);
    endtask

    initial begin
        tptd_pkg::in_t opening[$];
        int unsigned   map_plan[6];
        int unsigned   red_plan[6];
        map_plan = '{6, 10, 16, 31, 0, 9};
        red_plan = '{4, 8, 13, 31, 0, 20};

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Counts still at reset: nothing to grant.
        send_request(mk(tptd_pkg::ACT_ASK, tptd_pkg::KIND_REDUCE, 4'd15));
        wait_drained();
        set_counts(5'd3, 5'd2);

        opening = '{
            mk(tptd_pkg::ACT_ASK, tptd_pkg::KIND_MAP, 4'd0),
            mk(tptd_pkg::ACT_ASK, tptd_pkg::KIND_REDUCE, 4'd9),
            mk(tptd_pkg::ACT_ASK, tptd_pkg::KIND_MAP, 4'd6),
            mk(tptd_pkg::ACT_ASK, tptd_pkg::KIND_REDUCE, 4'd15),
            mk(tptd_pkg::ACT_SUBMIT, tptd_pkg::KIND_REDUCE, 4'd0),
            mk(tptd_pkg::ACT_SUBMIT, tptd_pkg::KIND_MAP, 4'd1),
            mk(tptd_pkg::ACT_SUBMIT, tptd_pkg::KIND_MAP, 4'd1),
            mk(tptd_pkg::ACT_SUBMIT, tptd_pkg::KIND_MAP, 4'd15),
            mk(tptd_pkg::ACT_SUBMIT, tptd_pkg::KIND_REDUCE, 4'd15),
            mk(tptd_pkg::ACT_ASK, tptd_pkg::KIND_MAP, 4'd0),
            mk(tptd_pkg::ACT_SUBMIT, tptd_pkg::KIND_MAP, 4'd0),
            mk(tptd_pkg::ACT_SUBMIT, tptd_pkg::KIND_MAP, 4'd2),
            mk(tptd_pkg::ACT_ASK, tptd_pkg::KIND_MAP, 4'd0),
            mk(tptd_pkg::ACT_ASK, tptd_pkg::KIND_MAP, 4'd0),
            mk(tptd_pkg::ACT_SUBMIT, tptd_pkg::KIND_MAP, 4'd3)
        };
        foreach (opening[i]) send_request(opening[i]);
        wait_drained();

        // Shrinking the reduce count: job done only rises on the next submit,
        // even a rejected one.
        set_counts(5'd3, 5'd1);
        send_request(mk(tptd_pkg::ACT_ASK, tptd_pkg::KIND_MAP, 4'd0));
        send_request(mk(tptd_pkg::ACT_SUBMIT, tptd_pkg::KIND_REDUCE, 4'd15));
        send_request(mk(tptd_pkg::ACT_ASK, tptd_pkg::KIND_REDUCE, 4'd5));
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            send_idle_pct = (p < 2) ? 11 : (p < 4) ? 63 : 0;
            recv_idle_pct = (p < 2) ? 63 : (p < 4) ? 11 : 0;
            set_counts(tptd_pkg::CNT_W'(map_plan[p]), tptd_pkg::CNT_W'(red_plan[p]));
            for (int n = 0; n < PHASE_ITEMS; n++) send_request(next_request());
            wait_drained();
        end

        repeat (24) @(negedge aclk);
        if (ledger.pending() != 0) begin
            $error("%0d response transactions never arrived", ledger.pending());
            ledger.errors++;
        end
        if (ledger.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/tptd_pkg.sv
sv/tptd_flag_bank.sv
sv/tptd_ctrl.sv
sv/two_phase_task_dispatcher.sv
sv/tptd_checker.sv
verif/two_phase_task_dispatcher_tb.sv
